FILE: rtl/dlm_pkg.sv
// shared types, constants and digit helpers for the decimal long multiplier
package dlm_pkg;

  localparam int unsigned MAX_DIGITS_DEF     = 32;
  localparam int unsigned PRODUCT_DIGITS_DEF = 64;
  localparam int unsigned DIGIT_W            = 4;
  localparam int unsigned LEN_W              = 6;
  localparam int unsigned POS_W              = 6;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  typedef struct packed {
    logic               bank;
    logic [LEN_W-1:0]   first_len;
    logic [LEN_W-1:0]   second_len;
    logic               negative;
    logic               overflow;
  } job_t;

  typedef struct packed {
    logic               en;
    logic               op;
    logic               bank;
    logic [LEN_W-2:0]   idx;
    logic [DIGIT_W-1:0] digit;
  } store_wr_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_RD,
    BK_MUL_WR,
    BK_CARRY,
    BK_SCAN_RD,
    BK_SCAN_CK,
    BK_EMIT_RD,
    BK_EMIT_OUT,
    BK_ZERO
  } back_state_e;

  function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  // valid for sums up to 99: multiply by 205/2048
  function automatic logic [DIGIT_W-1:0] div10(input logic [6:0] s);
    logic [14:0] p;
    p = 15'(s) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [DIGIT_W-1:0] mod10(input logic [6:0] s);
    logic [6:0] t;
    t = s - 7'(div10(s)) * 7'd10;
    return t[3:0];
  endfunction

endpackage

FILE: rtl/dlm_queue.sv
// two-entry job queue between the digit loader and the multiply engine
module dlm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlm_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output dlm_pkg::job_t job_o
);
  import dlm_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = QUEUE_DEPTH[CNT_W-1:0];
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CNT_FULL) || do_pop)
    else $error("job queue overrun");

endmodule

FILE: rtl/dlm_front.sv
// digit loader: takes input beats, fills the operand banks and queues products
module dlm_front #(
  parameter int unsigned MAX_DIGITS = dlm_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [dlm_pkg::DIGIT_W-1:0]   digit_i,
  input  logic                          negative_i,
  input  logic                          last_i,
  input  logic                          done_i,
  output dlm_pkg::store_wr_t            wr_o,
  output logic                          push_o,
  output dlm_pkg::job_t                 job_o
);
  import dlm_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN   = MAX_DIGITS[LEN_W-1:0];
  localparam logic [1:0]       JOBS_FULL = QUEUE_DEPTH[1:0];

  logic             bank_q, bank_d;
  logic [LEN_W-1:0] first_len_q, first_len_d;
  logic [LEN_W-1:0] second_len_q, second_len_d;
  logic             closed_q, closed_d;
  logic             sign_q, sign_d;
  logic             ovf_q, ovf_d;
  logic [1:0]       jobs_q, jobs_d;

  logic             accept;
  logic [LEN_W-1:0] eff_first;
  logic [LEN_W-1:0] sec_len_n;
  logic             ovf_n;

  assign busy_o    = (jobs_q == JOBS_FULL);
  assign accept    = start_i && !busy_o;
  // a first-operand beat after the close starts a new number
  assign eff_first = closed_q ? '0 : first_len_q;

  always_comb begin
    bank_d       = bank_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    closed_d     = closed_q;
    sign_d       = sign_q;
    ovf_d        = ovf_q;
    sec_len_n    = second_len_q;
    ovf_n        = ovf_q;
    push_o       = 1'b0;
    wr_o.en      = 1'b0;
    wr_o.op      = op_i;
    wr_o.bank    = bank_q;
    wr_o.idx     = '0;
    wr_o.digit   = clamp_digit(digit_i);
    job_o.bank       = bank_q;
    job_o.first_len  = first_len_q;
    job_o.second_len = second_len_q;
    job_o.negative   = sign_q ^ negative_i;
    job_o.overflow   = ovf_q;

    if (accept) begin
      if (op_i == OP_FIRST) begin
        closed_d    = last_i;
        first_len_d = eff_first;
        if (eff_first < MAX_LEN) begin
          wr_o.en     = 1'b1;
          wr_o.idx    = eff_first[LEN_W-2:0];
          first_len_d = eff_first + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        if (last_i) begin
          sign_d = negative_i;
        end
      end else begin
        if (second_len_q < MAX_LEN) begin
          wr_o.en   = 1'b1;
          wr_o.idx  = second_len_q[LEN_W-2:0];
          sec_len_n = second_len_q + 1'b1;
        end else begin
          ovf_n = 1'b1;
        end
        if (last_i) begin
          push_o           = 1'b1;
          job_o.second_len = sec_len_n;
          job_o.overflow   = ovf_n;
          first_len_d      = '0;
          second_len_d     = '0;
          closed_d         = 1'b0;
          ovf_d            = 1'b0;
          bank_d           = ~bank_q;
        end else begin
          second_len_d = sec_len_n;
          ovf_d        = ovf_n;
        end
      end
    end

    jobs_d = jobs_q;
    if (push_o && !done_i) begin
      jobs_d = jobs_q + 1'b1;
    end else if (!push_o && done_i) begin
      jobs_d = jobs_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q       <= 1'b0;
      first_len_q  <= '0;
      second_len_q <= '0;
      closed_q     <= 1'b0;
      sign_q       <= 1'b0;
      ovf_q        <= 1'b0;
      jobs_q       <= '0;
    end else begin
      bank_q       <= bank_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      closed_q     <= closed_d;
      sign_q       <= sign_d;
      ovf_q        <= ovf_d;
      jobs_q       <= jobs_d;
    end
  end

  a_done_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> jobs_q != '0)
    else $error("product finished with no job in flight");

endmodule

FILE: rtl/dlm_back.sv
// multiply engine: operand banks, schoolbook row loop, product store and digit emission
module dlm_back #(
  parameter int unsigned MAX_DIGITS     = dlm_pkg::MAX_DIGITS_DEF,
  parameter int unsigned PRODUCT_DIGITS = dlm_pkg::PRODUCT_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlm_pkg::store_wr_t            wr_i,
  input  logic                          job_valid_i,
  input  dlm_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  output logic                          done_o,
  output logic                          strobe_o,
  output logic [dlm_pkg::DIGIT_W-1:0]   digit_res_o,
  output logic                          negative_res_o,
  output logic                          overflow_o,
  output logic                          last_res_o
);
  import dlm_pkg::*;

  localparam int unsigned IW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned PAW = $clog2(PRODUCT_DIGITS);
  localparam logic [POS_W:0] PD_L = PRODUCT_DIGITS[POS_W:0];

  logic [DIGIT_W-1:0] first_mem  [2][MAX_DIGITS];
  logic [DIGIT_W-1:0] second_mem [2][MAX_DIGITS];
  logic [DIGIT_W-1:0] prod_mem   [PRODUCT_DIGITS];

  back_state_e        state_q, state_d;
  job_t               job_q, job_d;
  logic [LEN_W-2:0]   a_q, a_d;
  logic [LEN_W-2:0]   b_q, b_d;
  logic [DIGIT_W-1:0] carry_q, carry_d;
  logic [POS_W-1:0]   k_q, k_d;
  logic               ovf_q, ovf_d;

  logic               res_valid_q, res_valid_d;
  logic [DIGIT_W-1:0] res_digit_q, res_digit_d;
  logic               res_neg_q, res_neg_d;
  logic               res_ovf_q, res_ovf_d;
  logic               res_last_q, res_last_d;

  logic [DIGIT_W-1:0] fd_q, sd_q, pd_q;
  logic [LEN_W-1:0]   fidx, sidx;
  logic [POS_W-1:0]   pos, cpos;
  logic               pos_ok, cpos_ok;
  logic               row_end, col_end;
  logic [DIGIT_W-1:0] cur;
  logic [6:0]         sum;
  logic [DIGIT_W-1:0] sum_q10, sum_r10;
  logic [POS_W:0]     len_sum, top_lim;
  logic [POS_W-1:0]   k_start;

  logic               pwr_en;
  logic [PAW-1:0]     pwr_addr;
  logic [DIGIT_W-1:0] pwr_data;
  logic [PAW-1:0]     prd_addr;

  // digits are stored most significant first, rows run from the least significant
  assign fidx    = job_q.first_len - 1'b1 - LEN_W'(a_q);
  assign sidx    = job_q.second_len - 1'b1 - LEN_W'(b_q);
  assign pos     = POS_W'(a_q) + POS_W'(b_q);
  assign cpos    = POS_W'(a_q) + job_q.second_len;
  assign pos_ok  = {1'b0, pos} < PD_L;
  assign cpos_ok = {1'b0, cpos} < PD_L;
  assign col_end = (LEN_W'(b_q) == job_q.second_len - 1'b1);
  assign row_end = (LEN_W'(a_q) == job_q.first_len - 1'b1);

  // row zero sees an empty product, later rows read what earlier rows left
  assign cur     = ((a_q == '0) || !pos_ok) ? '0 : pd_q;
  assign sum     = 7'(fd_q) * 7'(sd_q) + 7'(cur) + 7'(carry_q);
  assign sum_q10 = div10(sum);
  assign sum_r10 = mod10(sum);

  assign len_sum = {1'b0, job_q.first_len} + {1'b0, job_q.second_len};
  assign top_lim = (len_sum < PD_L) ? len_sum : PD_L;
  assign k_start = top_lim[POS_W-1:0] - 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.op == OP_FIRST) begin
        first_mem[wr_i.bank][wr_i.idx[IW-1:0]] <= wr_i.digit;
      end else begin
        second_mem[wr_i.bank][wr_i.idx[IW-1:0]] <= wr_i.digit;
      end
    end
    fd_q <= first_mem[job_q.bank][fidx[IW-1:0]];
    sd_q <= second_mem[job_q.bank][sidx[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      prod_mem[pwr_addr] <= pwr_data;
    end
    pd_q <= prod_mem[prd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          if ((job_i.first_len == '0) || (job_i.second_len == '0)) begin
            state_d = BK_ZERO;
          end else begin
            state_d = BK_MUL_RD;
          end
        end
      end
      BK_MUL_RD:   state_d = BK_MUL_WR;
      BK_MUL_WR:   state_d = col_end ? BK_CARRY : BK_MUL_RD;
      BK_CARRY:    state_d = row_end ? BK_SCAN_RD : BK_MUL_RD;
      BK_SCAN_RD:  state_d = BK_SCAN_CK;
      BK_SCAN_CK: begin
        if (k_q == '0) begin
          state_d = BK_IDLE;
        end else if (pd_q != '0) begin
          state_d = BK_EMIT_RD;
        end else begin
          state_d = BK_SCAN_RD;
        end
      end
      BK_EMIT_RD:  state_d = BK_EMIT_OUT;
      BK_EMIT_OUT: state_d = (k_q == '0) ? BK_IDLE : BK_EMIT_RD;
      BK_ZERO:     state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  // datapath and result beats
  always_comb begin
    job_d       = job_q;
    a_d         = a_q;
    b_d         = b_q;
    carry_d     = carry_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    job_pop_o   = 1'b0;
    pwr_en      = 1'b0;
    pwr_addr    = pos[PAW-1:0];
    pwr_data    = sum_r10;
    prd_addr    = pos[PAW-1:0];
    res_valid_d = 1'b0;
    res_digit_d = res_digit_q;
    res_neg_d   = res_neg_q;
    res_ovf_d   = res_ovf_q;
    res_last_d  = res_last_q;

    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          ovf_d     = job_i.overflow;
          a_d       = '0;
          b_d       = '0;
          carry_d   = '0;
        end
      end
      BK_MUL_RD: begin
      end
      BK_MUL_WR: begin
        if (pos_ok) begin
          pwr_en = 1'b1;
        end else if (sum_r10 != '0) begin
          ovf_d = 1'b1;
        end
        carry_d = sum_q10;
        if (!col_end) begin
          b_d = b_q + 1'b1;
        end
      end
      BK_CARRY: begin
        // the carry slot is written even when zero so the next row reads it clean
        pwr_addr = cpos[PAW-1:0];
        pwr_data = carry_q;
        if (cpos_ok) begin
          pwr_en = 1'b1;
        end else if (carry_q != '0) begin
          ovf_d = 1'b1;
        end
        if (row_end) begin
          k_d = k_start;
        end else begin
          a_d     = a_q + 1'b1;
          b_d     = '0;
          carry_d = '0;
        end
      end
      BK_SCAN_RD: begin
        prd_addr = k_q[PAW-1:0];
      end
      BK_SCAN_CK: begin
        if (pd_q != '0) begin
          res_valid_d = 1'b1;
          res_digit_d = pd_q;
          res_neg_d   = job_q.negative;
          res_ovf_d   = ovf_q;
          res_last_d  = (k_q == '0);
        end else if (k_q == '0) begin
          // all digits zero: one unsigned zero
          res_valid_d = 1'b1;
          res_digit_d = '0;
          res_neg_d   = 1'b0;
          res_ovf_d   = ovf_q;
          res_last_d  = 1'b1;
        end
        if (k_q != '0) begin
          k_d = k_q - 1'b1;
        end
      end
      BK_EMIT_RD: begin
        prd_addr = k_q[PAW-1:0];
      end
      BK_EMIT_OUT: begin
        res_valid_d = 1'b1;
        res_digit_d = pd_q;
        res_neg_d   = job_q.negative;
        res_ovf_d   = ovf_q;
        res_last_d  = (k_q == '0);
        if (k_q != '0) begin
          k_d = k_q - 1'b1;
        end
      end
      BK_ZERO: begin
        res_valid_d = 1'b1;
        res_digit_d = '0;
        res_neg_d   = 1'b0;
        res_ovf_d   = ovf_q;
        res_last_d  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    a_q         <= a_d;
    b_q         <= b_d;
    carry_q     <= carry_d;
    k_q         <= k_d;
    ovf_q       <= ovf_d;
    res_digit_q <= res_digit_d;
    res_neg_q   <= res_neg_d;
    res_ovf_q   <= res_ovf_d;
    res_last_q  <= res_last_d;
  end

  assign strobe_o       = res_valid_q;
  assign digit_res_o    = res_digit_q;
  assign negative_res_o = res_neg_q;
  assign overflow_o     = res_ovf_q;
  assign last_res_o     = res_last_q;
  assign done_o         = res_valid_q && res_last_q;

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_digit_q <= 4'd9)
    else $error("product digit out of decimal range");

  a_beat_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_last_q |-> ##2 res_valid_q)
    else $error("gap inside a product");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_last_q |=> !res_valid_q)
    else $error("beat after the final product digit");

endmodule

FILE: rtl/decimal_long_multiplier.sv
// top level of the signed decimal long multiplier
// Operand digits enter one beat per cycle, most significant first, on start while busy is
// low; the last beat of the second number queues a product. Two operand banks let the next
// pair load while a product is worked; busy rises once two products are held and falls
// when the older one has sent its final digit. A product of L1 by L2 digits runs the
// schoolbook row loop (one shared 4x4 multiply and decimal carry step, a read and a write
// of the product store per digit pair, one carry write per row), then a leading-zero
// search and output over the top min(L1+L2, PRODUCT_DIGITS) product digits. An empty
// operand gives a single zero.
// Result beats come with strobe_o high for one cycle each, and the receiver cannot
// stall them.
module decimal_long_multiplier #(
  parameter int unsigned MAX_DIGITS     = dlm_pkg::MAX_DIGITS_DEF,
  parameter int unsigned PRODUCT_DIGITS = dlm_pkg::PRODUCT_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [dlm_pkg::DIGIT_W-1:0]   digit_i,
  input  logic                          negative_i,
  input  logic                          last_i,
  output logic                          strobe_o,
  output logic [dlm_pkg::DIGIT_W-1:0]   digit_res_o,
  output logic                          negative_res_o,
  output logic                          overflow_o,
  output logic                          last_res_o
);
  import dlm_pkg::*;

  store_wr_t wr;
  job_t      push_job;
  job_t      head_job;
  logic      push;
  logic      pop;
  logic      head_valid;
  logic      done;

  dlm_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .op_i       (op_i),
    .digit_i    (digit_i),
    .negative_i (negative_i),
    .last_i     (last_i),
    .done_i     (done),
    .wr_o       (wr),
    .push_o     (push),
    .job_o      (push_job)
  );

  dlm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  dlm_back #(
    .MAX_DIGITS     (MAX_DIGITS),
    .PRODUCT_DIGITS (PRODUCT_DIGITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .job_valid_i    (head_valid),
    .job_i          (head_job),
    .job_pop_o      (pop),
    .done_o         (done),
    .strobe_o       (strobe_o),
    .digit_res_o    (digit_res_o),
    .negative_res_o (negative_res_o),
    .overflow_o     (overflow_o),
    .last_res_o     (last_res_o)
  );

endmodule
